// ===== hdl/fri_pkg.sv =====
// Shared constants and field widths for the fuzzy rule inference engine.
// Used by the channel interfaces, the divider and the top level.
`default_nettype none
package fri_pkg;

  localparam int NUM_RULES_DEF       = 15;
  localparam int NUM_SETS_DEF        = 5;
  localparam int MAX_INPUTS_DEF      = 5;
  localparam int RULES_PER_LEVEL_DEF = 3;

  localparam int KIND_W   = 3;
  localparam int X_W      = 8;
  localparam int IDX_W    = 7;
  localparam int VAL_W    = 12;
  localparam int Y_W      = 4;
  localparam int CFG_W    = 3;
  localparam int CENTRE_W = 12;
  localparam int WIDTH_W  = 11;
  localparam int WEIGHT_W = 8;
  localparam int GRADE_W  = 16;

  // Divider geometry: quotient bits, numerator and denominator widths.
  localparam int QUOT_W    = 17;
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 49;

  // Small width guard added to every set width (0.0001 in Q.16).
  localparam int WIDTH_EPS = 7;

  localparam logic [KIND_W-1:0] KIND_EVAL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CENTRE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WIDTH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RULE   = 3'd4;

endpackage
`default_nettype wire

// ===== hdl/fri_if.sv =====
// Valid/ready channel interfaces for input items and results.
// Depends on fri_pkg for the field widths.
`default_nettype none
interface fri_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [fri_pkg::KIND_W-1:0]     kind;
  logic signed [fri_pkg::X_W-1:0]        x0;
  logic signed [fri_pkg::X_W-1:0]        x1;
  logic signed [fri_pkg::X_W-1:0]        x2;
  logic signed [fri_pkg::X_W-1:0]        x3;
  logic signed [fri_pkg::X_W-1:0]        x4;
  logic        [fri_pkg::IDX_W-1:0]      entry_index;
  logic signed [fri_pkg::VAL_W-1:0]      write_value;

  modport source (output valid, kind, x0, x1, x2, x3, x4, entry_index, write_value,
                  input ready);
  modport sink   (input valid, kind, x0, x1, x2, x3, x4, entry_index, write_value,
                  output ready);
endinterface

interface fri_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fri_pkg::Y_W-1:0]    y;
  logic                              no_strength;

  modport source (output valid, y, no_strength, input ready);
  modport sink   (input valid, y, no_strength, output ready);
endinterface
`default_nettype wire

// ===== hdl/fuzzy_rule_inference.sv =====
// Zero-order fuzzy inference engine with weighted-average output.
// An evaluate runs each membership (rule table read, offset, squares, divide)
// for every input in use of every rule, then forms each rule strength and the
// level maximum, accumulates every level and ends with a final divide.
// One item at a time; the shared divider sets the rate.
// Reset clears control state and sets inputs_in_use to 5; stores stay unwritten.
`default_nettype none
module fuzzy_rule_inference #(
  parameter int NUM_RULES       = fri_pkg::NUM_RULES_DEF,
  parameter int NUM_SETS        = fri_pkg::NUM_SETS_DEF,
  parameter int MAX_INPUTS      = fri_pkg::MAX_INPUTS_DEF,
  parameter int RULES_PER_LEVEL = fri_pkg::RULES_PER_LEVEL_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [fri_pkg::CFG_W-1:0]   cfg_wdata,
  fri_in_if.sink                           req,
  fri_out_if.source                        rsp
);
  localparam int NUM_LEVELS = NUM_RULES / RULES_PER_LEVEL;
  localparam int RT_DEPTH   = NUM_RULES * MAX_INPUTS;
  localparam int A_W  = $clog2(RT_DEPTH);
  localparam int S_W  = $clog2(NUM_SETS);
  localparam int R_W  = $clog2(NUM_RULES);
  localparam int J_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int N_W  = $clog2(MAX_INPUTS + 1);
  localparam int G_W  = (RULES_PER_LEVEL > 1) ? $clog2(RULES_PER_LEVEL) : 1;
  localparam int K_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int LV_W = K_W + 3;
  localparam int GW   = fri_pkg::GRADE_W;
  localparam int ST_W = fri_pkg::WEIGHT_W + GW;
  localparam int ACC_W = 40;
  localparam int XW   = fri_pkg::X_W;
  localparam int CTW  = fri_pkg::CENTRE_W;
  localparam int WDW  = fri_pkg::WIDTH_W;
  localparam int QW   = fri_pkg::QUOT_W;
  localparam int VAL_MSB = fri_pkg::VAL_W - 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_SUB  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_RULE = 4'd5;
  localparam logic [3:0] ST_MAX  = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;
  localparam logic [3:0] ST_FDIV = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0] state;
  logic [fri_pkg::CFG_W-1:0] inputs_in_use;

  logic signed [CTW-1:0]           centre [NUM_SETS];
  logic        [WDW-1:0]           swidth [NUM_SETS];
  logic        [fri_pkg::WEIGHT_W-1:0] weight [NUM_RULES];
  logic        [S_W-1:0]           rule_mem [RT_DEPTH];
  logic        [S_W-1:0]           rt_q;
  logic        [A_W-1:0]           rt_waddr;
  logic        [S_W-1:0]           rt_wdata;
  logic                            rt_we;

  logic signed [XW-1:0] xs [MAX_INPUTS];
  logic [N_W-1:0]  n_use;
  logic [J_W-1:0]  j;
  logic [R_W-1:0]  rr;
  logic [G_W-1:0]  gi;
  logic [K_W-1:0]  k;
  logic [A_W-1:0]  addr;
  logic [A_W-1:0]  row_base;
  logic [GW-1:0]   lo;
  logic [ST_W-1:0] best;
  logic [ST_W-1:0] strength;
  logic signed [ACC_W-1:0] num_acc;
  logic [ACC_W-1:0] den_acc;
  logic [15:0]     absd;
  logic [19:0]     creg;
  logic signed [fri_pkg::Y_W-1:0] y_res;
  logic            ns_res;

  logic signed [17:0] dval;
  logic [39:0] c2;
  logic [31:0] d2;
  logic [GW-1:0] g;
  logic [GW-1:0] lo_next;
  logic [ST_W-1:0] best_next;
  logic signed [LV_W-1:0] lvl;
  logic signed [LV_W+ST_W:0] lvl_prod;
  logic [ACC_W-1:0] num_mag;
  logic signed [XW-1:0] x_sel;
  logic [N_W-1:0] n_cfg;

  logic                               div_start;
  logic [fri_pkg::DIV_NUM_W-1:0]      div_num;
  logic [fri_pkg::DIV_DEN_W-1:0]      div_den;
  logic                               div_busy;
  logic                               div_done;
  logic [QW-1:0]                      div_q;

  fri_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    if (inputs_in_use == '0) begin
      n_cfg = N_W'(1);
    end else if (32'(inputs_in_use) > MAX_INPUTS) begin
      n_cfg = N_W'(MAX_INPUTS);
    end else begin
      n_cfg = N_W'(inputs_in_use);
    end
  end

  assign x_sel = xs[j];
  assign dval  = {{2{x_sel[XW-1]}}, x_sel, 8'h00} - {{(18-CTW){centre[rt_q][CTW-1]}},
                 centre[rt_q]};
  assign c2    = creg * creg;
  assign d2    = absd * absd;
  assign g     = div_q[QW-1] ? {GW{1'b1}} : div_q[GW-1:0];
  assign lo_next   = (g < lo) ? g : lo;
  assign best_next = (strength > best) ? strength : best;
  assign lvl     = $signed({1'b0, k, 1'b0}) - LV_W'(5);
  assign lvl_prod = lvl * $signed({1'b0, best});
  assign num_mag = num_acc[ACC_W-1] ? ACC_W'(-num_acc) : ACC_W'(num_acc);

  always_comb begin
    div_start = 1'b0;
    div_num   = {c2, 16'h0000};
    div_den   = {9'b0, c2} + {1'b0, d2, 16'h0000};
    if (state == ST_MUL) begin
      div_start = 1'b1;
    end else if (state == ST_FIN) begin
      div_num   = fri_pkg::DIV_NUM_W'(num_mag);
      div_den   = fri_pkg::DIV_DEN_W'(den_acc);
      div_start = (den_acc != '0);
    end
  end

  // Rule table write port, decoded from a write item.
  always_comb begin
    rt_we    = 1'b0;
    rt_waddr = A_W'(req.entry_index);
    if (req.write_value < 0) begin
      rt_wdata = '0;
    end else if (32'(req.write_value) >= NUM_SETS) begin
      rt_wdata = S_W'(NUM_SETS - 1);
    end else begin
      rt_wdata = S_W'(req.write_value);
    end
    if (req.valid && req.ready && req.kind == fri_pkg::KIND_RULE &&
        32'(req.entry_index) < RT_DEPTH) begin
      rt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rule_mem[rt_waddr] <= rt_wdata;
    end
    rt_q <= rule_mem[addr];
  end

  // Small parameter stores, written only from the idle state.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      case (req.kind)
        fri_pkg::KIND_CENTRE: begin
          if (32'(req.entry_index) < NUM_SETS) begin
            centre[S_W'(req.entry_index)] <= req.write_value;
          end
        end
        fri_pkg::KIND_WIDTH: begin
          if (32'(req.entry_index) < NUM_SETS) begin
            swidth[S_W'(req.entry_index)] <= req.write_value[VAL_MSB] ? '0 :
                                             req.write_value[WDW-1:0];
          end
        end
        fri_pkg::KIND_WEIGHT: begin
          if (32'(req.entry_index) < NUM_RULES) begin
            if (req.write_value < 0) begin
              weight[R_W'(req.entry_index)] <= '0;
            end else if (req.write_value > 255) begin
              weight[R_W'(req.entry_index)] <= '1;
            end else begin
              weight[R_W'(req.entry_index)] <= req.write_value[7:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use <= fri_pkg::CFG_W'(5);
    end else if (cfg_we) begin
      inputs_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // The output state reloads the register itself when it is freed.
      if (rsp.valid && rsp.ready && state != ST_OUT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid && req.kind == fri_pkg::KIND_EVAL) begin
            for (int i = 0; i < MAX_INPUTS; i++) begin
              case (i)
                0: xs[i] <= req.x0;
                1: xs[i] <= req.x1;
                2: xs[i] <= req.x2;
                3: xs[i] <= req.x3;
                4: xs[i] <= req.x4;
                default: xs[i] <= '0;
              endcase
            end
            n_use    <= n_cfg;
            j        <= '0;
            rr       <= '0;
            gi       <= '0;
            k        <= '0;
            addr     <= '0;
            row_base <= '0;
            lo       <= '1;
            best     <= '0;
            num_acc  <= '0;
            den_acc  <= '0;
            state    <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_SUB;
        end
        ST_SUB: begin
          absd  <= dval[17] ? 16'(-dval) : dval[15:0];
          creg  <= {1'b0, swidth[rt_q], 8'h00} + 20'(fri_pkg::WIDTH_EPS);
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            lo <= lo_next;
            if (N_W'({1'b0, j}) + N_W'(1) < n_use) begin
              j     <= j + 1'b1;
              addr  <= addr + 1'b1;
              state <= ST_RD;
            end else begin
              state <= ST_RULE;
            end
          end
        end
        ST_RULE: begin
          strength <= weight[rr] * lo;
          state    <= ST_MAX;
        end
        ST_MAX: begin
          best     <= best_next;
          lo       <= '1;
          j        <= '0;
          rr       <= rr + 1'b1;
          row_base <= row_base + A_W'(MAX_INPUTS);
          addr     <= row_base + A_W'(MAX_INPUTS);
          if (gi == G_W'(RULES_PER_LEVEL - 1)) begin
            gi    <= '0;
            state <= ST_ACC;
          end else begin
            gi    <= gi + 1'b1;
            state <= ST_RD;
          end
        end
        ST_ACC: begin
          den_acc <= den_acc + ACC_W'(best);
          num_acc <= num_acc + ACC_W'(lvl_prod);
          best    <= '0;
          if (k == K_W'(NUM_LEVELS - 1)) begin
            state <= ST_FIN;
          end else begin
            k     <= k + 1'b1;
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (den_acc == '0) begin
            y_res  <= '0;
            ns_res <= 1'b1;
            state  <= ST_OUT;
          end else begin
            ns_res <= 1'b0;
            state  <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          if (div_done) begin
            // Magnitude quotient truncates toward zero; apply sign and saturate.
            if (num_acc[ACC_W-1]) begin
              y_res <= (div_q > QW'(8)) ? -4'sd8 : -$signed(div_q[3:0]);
            end else begin
              y_res <= (div_q > QW'(7)) ? 4'sd7 : $signed(div_q[3:0]);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.y           <= y_res;
            rsp.no_strength <= ns_res;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == fri_pkg::KIND_EVAL) |=> state == ST_RD)
    else $error("evaluate transaction did not start the sequencer");

  a_no_strength_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.no_strength) |-> rsp.y == '0)
    else $error("result flagged without strength carries a nonzero value");
`endif

endmodule
`default_nettype wire

// ===== hdl/fri_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fri_pkg for its widths; the quotient must fit in QUOT_W bits.
`default_nettype none
module fri_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [fri_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [fri_pkg::DIV_DEN_W-1:0]    den,
  output logic                                  busy,
  output logic                                  done,
  output logic      [fri_pkg::QUOT_W-1:0]       quot
);
  localparam int QW   = fri_pkg::QUOT_W;
  localparam int NW   = fri_pkg::DIV_NUM_W;
  localparam int SH_W = fri_pkg::DIV_DEN_W + QW - 1;
  localparam int CW   = $clog2(QW);

  logic [NW-1:0]   rem;
  logic [SH_W-1:0] dsh;
  logic [CW-1:0]   cnt;
  logic            ge;

  assign ge = SH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= '0;
        rem  <= num;
        dsh  <= {den, {(QW-1){1'b0}}};
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh[NW-1:0];
        end
        quot <= {quot[QW-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
